// ===== rtl/cube_grid_to_sphere_points_defines.svh =====
`ifndef CUBE_GRID_TO_SPHERE_POINTS_DEFINES_SVH
`define CUBE_GRID_TO_SPHERE_POINTS_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define CGSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define CGSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cgsp_pkg.sv =====
`default_nettype none

package cgsp_pkg;

    // Grid and number format
    localparam int MAX_LEVEL = 10;
    localparam int FRAC_BITS = 12;
    localparam int IDX_W     = 10;
    localparam int LVL_W     = 4;
    localparam int CLV_W     = (MAX_LEVEL < 2) ? 1 : $clog2(MAX_LEVEL + 1);
    localparam int RAD_W     = 16;
    localparam int COORD_W   = 17;
    localparam int FACE_W    = 3;

    // Fixed-point alignment of radius (12 fraction bits) to the output format
    localparam int UP_SHIFT  = (FRAC_BITS >= 12) ? (FRAC_BITS - 12) : 0;
    localparam int DN_SHIFT  = (FRAC_BITS < 12) ? (2 * (12 - FRAC_BITS)) : 0;

    // Datapath widths
    localparam int MAG_W     = MAX_LEVEL + 1;
    localparam int S_W       = 2 * MAG_W;
    localparam int EXT_W     = (IDX_W + 1 > MAG_W) ? (IDX_W + 1) : MAG_W;
    localparam int NUM_W     = RAD_W + MAG_W + UP_SHIFT;
    localparam int SQ_W      = 2 * NUM_W + 2;
    localparam int DEN_W     = S_W + DN_SHIFT;
    localparam int ROOT_W    = COORD_W;
    localparam int Q_W       = 2 * ROOT_W;
    localparam int HI_W      = SQ_W - Q_W;
    localparam int CMP_W     = (HI_W > DEN_W) ? HI_W : DEN_W;

    // Quotient cap: any larger value rounds to the saturated magnitude
    localparam longint unsigned ROOT_MAX = (longint'(1) << ROOT_W) - 1;
    localparam logic [Q_W-1:0]  D_CAP    = Q_W'(ROOT_MAX * ROOT_MAX);

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_LEVEL  = 1'b0;
    localparam logic REG_RADIUS = 1'b1;
    localparam logic [RAD_W-1:0] RADIUS_RST = 16'd6144;

    // Face codes
    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    // Cell queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = FIFO_AW + 1;

    // One classified cell
    typedef struct packed {
        logic             err;
        logic [MAG_W-1:0] mag_n;
        logic [MAG_W-1:0] mag_a;
        logic             neg_a;
        logic [MAG_W-1:0] mag_b;
        logic             neg_b;
        logic [S_W-1:0]   s;
    } t_cell_desc;

    // Which magnitude a normalizer job carries
    typedef enum logic [1:0] {
        KIND_N = 2'd0,
        KIND_A = 2'd1,
        KIND_B = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  last;
        logic  err;
        logic  neg_a;
        logic  neg_b;
    } t_job_tag;

    // Signed, saturated coordinate from a rounded magnitude (at most 2^(COORD_W-1))
    function automatic logic signed [COORD_W-1:0] to_coord(input logic [COORD_W-1:0] q,
                                                           input logic neg);
        logic [COORD_W-1:0] r;
        if (neg) begin
            r = COORD_W'(0) - q;
        end else if (q[COORD_W-1]) begin
            r = COORD_MAX;
        end else begin
            r = q;
        end
        return signed'(r);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cgsp_if.sv =====
`default_nettype none

// Cell index word
interface cgsp_cell_if import cgsp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;

    modport source (output valid, output row_index, output col_index, input ready);
    modport sink   (input valid, input row_index, input col_index, output ready);
endinterface

// Sphere point word
interface cgsp_point_if import cgsp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FACE_W-1:0]         face;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      index_error;
    logic                      last_point;

    modport source (output valid, output face, output coord_x, output coord_y,
                    output coord_z, output index_error, output last_point, input ready);
    modport sink   (input valid, input face, input coord_x, input coord_y,
                    input coord_z, input index_error, input last_point, output ready);
endinterface

`default_nettype wire

// ===== rtl/cube_grid_to_sphere_points.sv =====
`default_nettype none
// Channel   Dir  Word                                        Per cell
// i_cell    in   row_index, col_index                        1
// o_point   out  face, coord_x/y/z, index_error, last_point  6, or 1 on index error
// APB       in   grid_level at 0x0, sphere_radius at 0x4     -
//
// One point leaves per cycle while o_point.ready is high; the output register
// sets that pace, and the normalizer takes only 3 jobs per cell.
// From accept to first point a cell passes classify, the queue, 56 normalizer stages
// (34 division steps, 17 square-root steps) and the output register.
// Reset is synchronous; no memory to clear. A stalled output backs up through
// the normalizer into the 4-entry cell queue before i_cell.ready drops.

`include "cube_grid_to_sphere_points_defines.svh"

module cube_grid_to_sphere_points import cgsp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    cgsp_cell_if.sink              i_cell,
    cgsp_point_if.source           o_point,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    logic [LVL_W-1:0]   r_level;
    logic [RAD_W-1:0]   r_radius;
    logic               cfg_wr;
    logic               fd_valid;
    logic               fd_ready;
    t_cell_desc         fd_desc;
    logic               bd_valid;
    logic               bd_ready;
    t_cell_desc         bd_desc;
    logic [FIFO_CW-1:0] q_count;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_radius <= RADIUS_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LEVEL:  r_level  <= pwdata[LVL_W-1:0];
                REG_RADIUS: r_radius <= pwdata[RAD_W-1:0];
                default:    r_level  <= r_level;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LEVEL:  prdata = DATA_W'(r_level);
            REG_RADIUS: prdata = DATA_W'(r_radius);
            default:    prdata = '0;
        endcase
    end

    cgsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_level      (r_level),
        .i_cell       (i_cell),
        .o_desc_valid (fd_valid),
        .i_desc_ready (fd_ready),
        .o_desc       (fd_desc)
    );

    cgsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fd_valid),
        .o_ready (fd_ready),
        .i_data  (fd_desc),
        .o_valid (bd_valid),
        .i_ready (bd_ready),
        .o_data  (bd_desc),
        .o_count (q_count)
    );

    cgsp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_radius     (r_radius),
        .i_desc_valid (bd_valid),
        .o_desc_ready (bd_ready),
        .i_desc       (bd_desc),
        .o_point      (o_point)
    );

    // Checks
    `CGSP_ASSERT_IMP(a_err_word, o_point.valid && o_point.index_error, o_point.last_point && o_point.face == FACE_PX && o_point.coord_x == '0 && o_point.coord_y == '0 && o_point.coord_z == '0, "index error word not zero and last")
    `CGSP_ASSERT_IMP(a_last_face, o_point.valid && o_point.last_point && !o_point.index_error, o_point.face == FACE_NZ, "last point not on the -z face")
    `CGSP_ASSERT_IMP(a_queue_bound, fd_valid || !fd_valid, q_count <= FIFO_CW'(FIFO_DEPTH), "cell queue overfilled")
    `CGSP_ASSERT_NXT(a_level_write, cfg_wr && paddr[2] == REG_LEVEL, r_level == $past(pwdata[LVL_W-1:0]), "grid level write lost")

endmodule

`default_nettype wire

// ===== rtl/cgsp_front.sv =====
`default_nettype none

module cgsp_front import cgsp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [LVL_W-1:0] i_level,
    cgsp_cell_if.sink             i_cell,
    output logic                  o_desc_valid,
    input  wire logic             i_desc_ready,
    output t_cell_desc            o_desc
);

    logic             r_valid;
    t_cell_desc       r_desc;
    t_cell_desc       n_desc;
    logic [CLV_W-1:0] lvl;
    logic [MAG_W-1:0] n_val;
    logic [EXT_W-1:0] n_ext;
    logic [EXT_W:0]   off_a;
    logic [EXT_W:0]   off_b;
    logic [S_W-1:0]   sq_a;
    logic [S_W-1:0]   sq_b;
    logic [S_W-1:0]   sq_n;
    logic             accept;

    // Signed offset 2*idx+1-n of a cell center, as {negative, magnitude}
    function automatic logic [EXT_W:0] off_center(input logic [IDX_W-1:0] idx,
                                                  input logic [EXT_W-1:0] n);
        logic [EXT_W-1:0] two_i;
        logic             neg;
        two_i = EXT_W'({idx, 1'b1});
        neg   = two_i < n;
        return {neg, neg ? (n - two_i) : (two_i - n)};
    endfunction

    assign accept       = i_cell.valid && i_cell.ready;
    assign i_cell.ready = !r_valid || i_desc_ready;

    // Classify: clamp level, range check, center offsets and squared norm
    always_comb begin
        lvl   = (i_level > LVL_W'(MAX_LEVEL)) ? CLV_W'(MAX_LEVEL) : CLV_W'(i_level);
        n_val = MAG_W'(1) << lvl;
        n_ext = EXT_W'(n_val);
        off_a = off_center(i_cell.row_index, n_ext);
        off_b = off_center(i_cell.col_index, n_ext);
        n_desc.err   = (EXT_W'(i_cell.row_index) >= n_ext) ||
                       (EXT_W'(i_cell.col_index) >= n_ext);
        n_desc.mag_n = n_val;
        n_desc.mag_a = MAG_W'(off_a[EXT_W-1:0]);
        n_desc.neg_a = off_a[EXT_W];
        n_desc.mag_b = MAG_W'(off_b[EXT_W-1:0]);
        n_desc.neg_b = off_b[EXT_W];
        sq_a = S_W'(n_desc.mag_a) * S_W'(n_desc.mag_a);
        sq_b = S_W'(n_desc.mag_b) * S_W'(n_desc.mag_b);
        sq_n = S_W'(1) << {lvl, 1'b0};
        n_desc.s = sq_n + sq_a + sq_b;
    end

    // Hold the word until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_desc_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= n_desc;
        end
    end

    assign o_desc_valid = r_valid;
    assign o_desc       = r_desc;

endmodule

`default_nettype wire

// ===== rtl/cgsp_fifo.sv =====
`default_nettype none

module cgsp_fifo import cgsp_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire t_cell_desc   i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output t_cell_desc        o_data,
    output logic [FIFO_CW-1:0] o_count
);

    localparam logic [FIFO_CW-1:0] FULL_CNT = FIFO_CW'(FIFO_DEPTH);

    t_cell_desc         r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_CW-1:0] r_count;
    logic               push;
    logic               pop;

    assign o_ready = r_count != FULL_CNT;
    assign o_valid = r_count != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + FIFO_AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cgsp_norm.sv =====
`default_nettype none

// Computes round(radius * mag / sqrt(s)), clamped to 2^(COORD_W-1).
// Long division of 4*num^2 by s, then integer square root, one bit per stage.
module cgsp_norm import cgsp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_job_tag         i_tag,
    input  wire logic [MAG_W-1:0] i_mag,
    input  wire logic [S_W-1:0]   i_s,
    input  wire logic [RAD_W-1:0] i_radius,
    output logic                  o_valid,
    output t_job_tag              o_tag,
    output logic [COORD_W-1:0]    o_q
);

    // Stage A: numerator radius * mag
    logic                     r_a_v;
    t_job_tag                 r_a_tag;
    logic [NUM_W-1:0]         r_a_num;
    logic [DEN_W-1:0]         r_a_den;
    logic [RAD_W+MAG_W-1:0]   prod;

    // Stage B: 4 * num^2
    logic                     r_b_v;
    t_job_tag                 r_b_tag;
    logic [SQ_W-1:0]          r_b_sq;
    logic [DEN_W-1:0]         r_b_den;
    logic [2*NUM_W-1:0]       psq;

    // Division stages, index 0 is the setup
    logic                     r_dv   [Q_W+1];
    t_job_tag                 r_dtag [Q_W+1];
    logic [DEN_W-1:0]         r_dden [Q_W+1];
    logic [DEN_W-1:0]         r_drem [Q_W+1];
    logic [Q_W-1:0]           r_dlow [Q_W+1];
    logic [Q_W-1:0]           r_dquo [Q_W+1];
    logic                     r_dovf [Q_W+1];
    logic [CMP_W-1:0]         hi_ext;
    logic                     ovf0;

    // Square-root stages, index 0 is the clamp
    logic                     r_sv    [ROOT_W+1];
    t_job_tag                 r_stag  [ROOT_W+1];
    logic [ROOT_W+1:0]        r_srem  [ROOT_W+1];
    logic [ROOT_W-1:0]        r_sroot [ROOT_W+1];
    logic [Q_W-1:0]           r_sd    [ROOT_W+1];

    // Final rounding stage
    logic                     r_qv;
    t_job_tag                 r_qtag;
    logic [COORD_W-1:0]       r_q;
    logic [ROOT_W:0]          rsum;

    assign prod   = (RAD_W+MAG_W)'(i_radius) * (RAD_W+MAG_W)'(i_mag);
    assign psq    = (2*NUM_W)'(r_a_num) * (2*NUM_W)'(r_a_num);
    assign hi_ext = CMP_W'(r_b_sq[SQ_W-1:Q_W]);
    assign ovf0   = hi_ext >= CMP_W'(r_b_den);
    assign rsum   = {1'b0, r_sroot[ROOT_W]} + (ROOT_W+1)'(1);

    // Advance the valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_dv[0] <= 1'b0;
            r_sv[0] <= 1'b0;
            r_qv  <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_dv[0] <= r_b_v;
            r_sv[0] <= r_dv[Q_W];
            r_qv  <= r_sv[ROOT_W];
        end
    end

    // Front stages, division setup, clamp and rounding
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_tag   <= i_tag;
            r_a_num   <= NUM_W'(prod) << UP_SHIFT;
            r_a_den   <= DEN_W'(i_s) << DN_SHIFT;
            r_b_tag   <= r_a_tag;
            r_b_sq    <= {psq, 2'b00};
            r_b_den   <= r_a_den;
            r_dtag[0] <= r_b_tag;
            r_dden[0] <= r_b_den;
            r_drem[0] <= ovf0 ? '0 : DEN_W'(hi_ext);
            r_dlow[0] <= r_b_sq[Q_W-1:0];
            r_dquo[0] <= '0;
            r_dovf[0] <= ovf0;
            r_stag[0]  <= r_dtag[Q_W];
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            r_sd[0]    <= (r_dovf[Q_W] || (r_dquo[Q_W] > D_CAP)) ? D_CAP : r_dquo[Q_W];
            r_qtag    <= r_stag[ROOT_W];
            r_q       <= COORD_W'(rsum[ROOT_W:1]);
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar d = 1; d <= Q_W; d++) begin : g_div
        logic [DEN_W:0] t;
        logic           ge;

        assign t  = {r_drem[d-1], r_dlow[d-1][Q_W-1]};
        assign ge = t >= {1'b0, r_dden[d-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[d] <= 1'b0;
            end else if (i_en) begin
                r_dv[d] <= r_dv[d-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dtag[d] <= r_dtag[d-1];
                r_dden[d] <= r_dden[d-1];
                r_drem[d] <= ge ? DEN_W'(t - {1'b0, r_dden[d-1]}) : DEN_W'(t);
                r_dlow[d] <= r_dlow[d-1] << 1;
                r_dquo[d] <= {r_dquo[d-1][Q_W-2:0], ge};
                r_dovf[d] <= r_dovf[d-1];
            end
        end
    end

    // Integer square root, one root bit per stage
    for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
        logic [ROOT_W+3:0] t;
        logic [ROOT_W+3:0] trial;
        logic              ge;

        assign t     = {r_srem[k-1], r_sd[k-1][Q_W-1 -: 2]};
        assign trial = {2'b00, r_sroot[k-1], 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else if (i_en) begin
                r_sv[k] <= r_sv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stag[k]  <= r_stag[k-1];
                r_srem[k]  <= ge ? (ROOT_W+2)'(t - trial) : (ROOT_W+2)'(t);
                r_sroot[k] <= {r_sroot[k-1][ROOT_W-2:0], ge};
                r_sd[k]    <= r_sd[k-1] << 2;
            end
        end
    end

    assign o_valid = r_qv;
    assign o_tag   = r_qtag;
    assign o_q     = r_q;

endmodule

`default_nettype wire

// ===== rtl/cgsp_back.sv =====
`default_nettype none

module cgsp_back import cgsp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [RAD_W-1:0] i_radius,
    input  wire logic             i_desc_valid,
    output logic                  o_desc_ready,
    input  wire t_cell_desc       i_desc,
    cgsp_point_if.source          o_point
);

    t_kind                     r_jk;
    t_job_tag                  job_tag;
    logic [MAG_W-1:0]          job_mag;
    logic                      job_last;
    logic                      adv;
    logic                      po_v;
    t_job_tag                  po_tag;
    logic [COORD_W-1:0]        po_q;
    logic                      take;
    logic                      capture;

    logic [COORD_W-1:0]        r_col_qn;
    logic [COORD_W-1:0]        r_col_qa;
    logic                      r_set_full;
    logic                      r_set_err;
    logic [COORD_W-1:0]        r_set_qn;
    logic [COORD_W-1:0]        r_set_qa;
    logic [COORD_W-1:0]        r_set_qb;
    logic                      r_set_nega;
    logic                      r_set_negb;
    logic                      set_free;

    logic [FACE_W-1:0]         r_pk;
    logic                      emit_adv;
    logic                      r_ov;
    logic [FACE_W-1:0]         r_face;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;
    logic                      r_err;
    logic                      r_last;
    logic signed [COORD_W-1:0] cn_p;
    logic signed [COORD_W-1:0] cn_m;
    logic signed [COORD_W-1:0] ca;
    logic signed [COORD_W-1:0] cb;
    logic signed [COORD_W-1:0] n_x;
    logic signed [COORD_W-1:0] n_y;
    logic signed [COORD_W-1:0] n_z;

    // Issue: three magnitude jobs per cell, one for an index error
    always_comb begin
        case (r_jk)
            KIND_N:  job_mag = i_desc.mag_n;
            KIND_A:  job_mag = i_desc.mag_a;
            KIND_B:  job_mag = i_desc.mag_b;
            default: job_mag = i_desc.mag_n;
        endcase
        job_last      = i_desc.err || (r_jk == KIND_B);
        job_tag.kind  = r_jk;
        job_tag.last  = job_last;
        job_tag.err   = i_desc.err;
        job_tag.neg_a = i_desc.neg_a;
        job_tag.neg_b = i_desc.neg_b;
    end

    assign o_desc_ready = adv && job_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jk <= KIND_N;
        end else if (adv && i_desc_valid) begin
            case (r_jk)
                KIND_N:  r_jk <= job_last ? KIND_N : KIND_A;
                KIND_A:  r_jk <= KIND_B;
                default: r_jk <= KIND_N;
            endcase
        end
    end

    cgsp_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (i_desc_valid),
        .i_tag    (job_tag),
        .i_mag    (job_mag),
        .i_s      (i_desc.s),
        .i_radius (i_radius),
        .o_valid  (po_v),
        .o_tag    (po_tag),
        .o_q      (po_q)
    );

    // Stall the normalizer only when a finished set cannot be parked
    assign emit_adv = r_set_full && (!r_ov || o_point.ready);
    assign set_free = emit_adv && (r_set_err || (r_pk == FACE_NZ));
    assign adv      = !(po_v && po_tag.last && r_set_full && !set_free);
    assign take     = adv && po_v;
    assign capture  = take && po_tag.last;

    // Collect magnitudes, park a complete set
    always_ff @(posedge i_clk) begin
        if (take && (po_tag.kind == KIND_N)) begin
            r_col_qn <= po_q;
        end
        if (take && (po_tag.kind == KIND_A)) begin
            r_col_qa <= po_q;
        end
        if (capture) begin
            r_set_err  <= po_tag.err;
            r_set_qn   <= r_col_qn;
            r_set_qa   <= r_col_qa;
            r_set_qb   <= po_q;
            r_set_nega <= po_tag.neg_a;
            r_set_negb <= po_tag.neg_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_full <= 1'b0;
            r_pk       <= FACE_PX;
        end else begin
            if (capture) begin
                r_set_full <= 1'b1;
            end else if (set_free) begin
                r_set_full <= 1'b0;
            end
            if (set_free) begin
                r_pk <= FACE_PX;
            end else if (emit_adv) begin
                r_pk <= r_pk + FACE_W'(1);
            end
        end
    end

    // Build the point for the current face
    assign cn_p = to_coord(r_set_qn, 1'b0);
    assign cn_m = to_coord(r_set_qn, 1'b1);
    assign ca   = to_coord(r_set_qa, r_set_nega);
    assign cb   = to_coord(r_set_qb, r_set_negb);

    always_comb begin
        case (r_pk)
            FACE_PX: begin n_x = cn_p; n_y = ca;   n_z = cb;   end
            FACE_NX: begin n_x = cn_m; n_y = ca;   n_z = cb;   end
            FACE_PY: begin n_x = ca;   n_y = cn_p; n_z = cb;   end
            FACE_NY: begin n_x = ca;   n_y = cn_m; n_z = cb;   end
            FACE_PZ: begin n_x = ca;   n_y = cb;   n_z = cn_p; end
            FACE_NZ: begin n_x = ca;   n_y = cb;   n_z = cn_m; end
            default: begin n_x = '0;   n_y = '0;   n_z = '0;   end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit_adv) begin
            r_ov <= 1'b1;
        end else if (o_point.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_adv) begin
            r_err  <= r_set_err;
            r_last <= r_set_err || (r_pk == FACE_NZ);
            if (r_set_err) begin
                r_face <= FACE_PX;
                r_x    <= '0;
                r_y    <= '0;
                r_z    <= '0;
            end else begin
                r_face <= r_pk;
                r_x    <= n_x;
                r_y    <= n_y;
                r_z    <= n_z;
            end
        end
    end

    assign o_point.valid       = r_ov;
    assign o_point.face        = r_face;
    assign o_point.coord_x     = r_x;
    assign o_point.coord_y     = r_y;
    assign o_point.coord_z     = r_z;
    assign o_point.index_error = r_err;
    assign o_point.last_point  = r_last;

endmodule

`default_nettype wire
